// File: rtl/nrmc_pkg.sv
`default_nettype none
package nrmc_pkg;

  // digits that leave the block on every result
  localparam int unsigned LAT_OUT = 5;
  localparam int unsigned LON_OUT = 4;

  localparam int unsigned LAT_DIGITS_DEF = 5;
  localparam int unsigned LON_DIGITS_DEF = 4;

  localparam int unsigned HDR_LEN = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_E      = 8'h45;

  localparam logic [HDR_LEN-1:0][7:0] HDR_SEQ = {
    CH_COMMA, CH_C, CH_M, CH_R, CH_N, CH_G, CH_DOLLAR
  };

  localparam logic [LAT_OUT-1:0][3:0] LAT_RST = {4'd4, 4'd2, 4'd3, 4'd1, 4'd1};
  localparam logic [LON_OUT-1:0][3:0] LON_RST = {4'd7, 4'd1, 4'd4, 4'd2};

  typedef enum logic [3:0] {
    ST_HDR0   = 4'd0,
    ST_HDR1   = 4'd1,
    ST_HDR2   = 4'd2,
    ST_HDR3   = 4'd3,
    ST_HDR4   = 4'd4,
    ST_HDR5   = 4'd5,
    ST_HDR6   = 4'd6,
    ST_TIME   = 4'd7,
    ST_STATUS = 4'd8,
    ST_LAT    = 4'd9,
    ST_NS     = 4'd10,
    ST_SKIP   = 4'd11,
    ST_LON    = 4'd12,
    ST_EW     = 4'd13
  } state_e;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

// File: rtl/nrmc_in_if.sv
`default_nettype none
interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/nrmc_out_if.sv
`default_nettype none
interface nrmc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] lat_digit_0;
  logic [3:0] lat_digit_1;
  logic [3:0] lat_digit_2;
  logic [3:0] lat_digit_3;
  logic [3:0] lat_digit_4;
  logic [3:0] lon_digit_0;
  logic [3:0] lon_digit_1;
  logic [3:0] lon_digit_2;
  logic [3:0] lon_digit_3;
  logic [7:0] hemisphere_ns;
  logic [7:0] hemisphere_ew;

  modport source (
    output valid, input ready,
    output lat_digit_0, output lat_digit_1, output lat_digit_2,
    output lat_digit_3, output lat_digit_4,
    output lon_digit_0, output lon_digit_1, output lon_digit_2, output lon_digit_3,
    output hemisphere_ns, output hemisphere_ew
  );
  modport sink (
    input valid, output ready,
    input lat_digit_0, input lat_digit_1, input lat_digit_2,
    input lat_digit_3, input lat_digit_4,
    input lon_digit_0, input lon_digit_1, input lon_digit_2, input lon_digit_3,
    input hemisphere_ns, input hemisphere_ew
  );
endinterface
`default_nettype wire

// File: rtl/nmea_rmc_position_parser_core.sv
// nmea rmc position parser
// in_i carries one received character per item (rx_byte). the block matches
// the "$GNRMC," header, skips time and status, keeps the latitude digits,
// the n/s byte, the longitude digits and the e/w byte, and on the e/w byte
// sends one item on out_o with the stored digits and both hemisphere bytes.
// any other byte gives no result item.
// the result item shows on out_o in the cycle after the e/w byte is
// accepted, from a result register.
// throughput is one item per cycle: in_i is ready whenever the result
// register is empty or being drained, and also when the parser is not
// waiting for an e/w byte, since only that byte writes the result register.
// if the receiver stalls out_o, the result holds and only an e/w byte waits.
// reset puts the parser back to header search and loads the stored digits
// and the n/s byte with their default position.
`default_nettype none
module nmea_rmc_position_parser_core #(
  parameter int unsigned LAT_DIGITS = nrmc_pkg::LAT_DIGITS_DEF,
  parameter int unsigned LON_DIGITS = nrmc_pkg::LON_DIGITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nrmc_in_if.sink     in_i,
  nrmc_out_if.source  out_o
);
  import nrmc_pkg::*;

  localparam int unsigned MAX_DIGITS = (LAT_DIGITS > LON_DIGITS) ? LAT_DIGITS : LON_DIGITS;
  localparam int unsigned DIDX_W     = $clog2(MAX_DIGITS + 1);

  state_e                    state_q, state_d;
  logic [DIDX_W-1:0]         didx_q, didx_d;
  logic [LAT_OUT-1:0][3:0]   lat_q, lat_d;
  logic [LON_OUT-1:0][3:0]   lon_q, lon_d;
  logic [7:0]                ns_q, ns_d;
  logic                      res_valid_q, res_valid_d;
  logic [7:0]                ew_res_q;
  logic [LAT_OUT-1:0][3:0]   lat_res_q;
  logic [LON_OUT-1:0][3:0]   lon_res_q;
  logic [7:0]                ns_res_q;
  logic                      in_fire;
  logic                      res_load;
  logic [7:0]                b;

  assign b        = in_i.rx_byte;
  assign in_i.ready = !res_valid_q || out_o.ready || (state_q != ST_EW);
  assign in_fire  = in_i.valid && in_i.ready;
  assign res_load = in_fire && (state_q == ST_EW);

  // next state
  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      case (state_q)
        ST_TIME, ST_STATUS, ST_SKIP, ST_LAT, ST_LON: begin
          if (b == CH_COMMA) begin
            state_d = state_e'(4'(state_q) + 4'd1);
          end
        end
        ST_NS: state_d = ST_SKIP;
        ST_EW: state_d = ST_HDR0;
        default: begin
          if (state_q < ST_TIME && b == HDR_SEQ[state_q[2:0]]) begin
            state_d = state_e'(4'(state_q) + 4'd1);
          end else begin
            // mismatch, or unused code
            state_d = ST_HDR0;
          end
        end
      endcase
    end
  end

  // field capture
  always_comb begin
    didx_d = didx_q;
    lat_d  = lat_q;
    lon_d  = lon_q;
    ns_d   = ns_q;
    if (in_fire) begin
      case (state_q)
        ST_LAT: begin
          if (b == CH_COMMA) begin
            didx_d = '0;
          end else if (is_digit(b) && didx_q < DIDX_W'(LAT_DIGITS)) begin
            for (int i = 0; i < LAT_OUT; i++) begin
              // ascii digits carry their value in the low nibble
              if (didx_q == DIDX_W'(i)) lat_d[i] = b[3:0];
            end
            didx_d = didx_q + DIDX_W'(1);
          end
        end
        ST_LON: begin
          if (b == CH_COMMA) begin
            didx_d = '0;
          end else if (is_digit(b) && didx_q < DIDX_W'(LON_DIGITS)) begin
            for (int i = 0; i < LON_OUT; i++) begin
              if (didx_q == DIDX_W'(i)) lon_d[i] = b[3:0];
            end
            didx_d = didx_q + DIDX_W'(1);
          end
        end
        ST_NS: ns_d = b;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (out_o.ready) res_valid_d = 1'b0;
    if (res_load) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HDR0;
      didx_q      <= '0;
      lat_q       <= LAT_RST;
      lon_q       <= LON_RST;
      ns_q        <= CH_N;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      didx_q      <= didx_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      ns_q        <= ns_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      lat_res_q <= lat_q;
      lon_res_q <= lon_q;
      ns_res_q  <= ns_q;
      ew_res_q  <= b;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.lat_digit_0   = lat_res_q[0];
  assign out_o.lat_digit_1   = lat_res_q[1];
  assign out_o.lat_digit_2   = lat_res_q[2];
  assign out_o.lat_digit_3   = lat_res_q[3];
  assign out_o.lat_digit_4   = lat_res_q[4];
  assign out_o.lon_digit_0   = lon_res_q[0];
  assign out_o.lon_digit_1   = lon_res_q[1];
  assign out_o.lon_digit_2   = lon_res_q[2];
  assign out_o.lon_digit_3   = lon_res_q[3];
  assign out_o.hemisphere_ns = ns_res_q;
  assign out_o.hemisphere_ew = ew_res_q;

  a_ew_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q)
    else $error("e/w byte accepted without a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_o.ready && state_q == ST_EW) |-> !in_i.ready)
    else $error("pending result could be overwritten");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(res_load))
    else $error("result appeared without an e/w byte");

  a_didx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    didx_q <= DIDX_W'(MAX_DIGITS))
    else $error("digit index out of range");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import nrmc_pkg::*;

  localparam int unsigned LAT_KEEP = LAT_DIGITS_DEF;
  localparam int unsigned LON_KEEP = LON_DIGITS_DEF;
  localparam int unsigned MEM_DEPTH = 8;

  typedef struct packed {
    logic [LAT_OUT-1:0][3:0] lat;
    logic [LON_OUT-1:0][3:0] lon;
    logic [7:0]              ns;
    logic [7:0]              ew;
  } fix_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    fix_t       fix;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  nrmc_in_if  in_if ();
  nrmc_out_if out_if ();

  nmea_rmc_position_parser_core #(
    .LAT_DIGITS (LAT_KEEP),
    .LON_DIGITS (LON_KEEP)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow parser state
  state_e      pst;
  int unsigned dig_idx;
  logic [3:0]  lat_mem [MEM_DEPTH];
  logic [3:0]  lon_mem [MEM_DEPTH];
  logic [7:0]  ns_byte;
  logic [7:0]  ew_byte;

  fix_t pending_fixes [$];
  int   errors = 0;
  int   sent = 0;
  int   src_idle = 22;
  int   snk_idle = 46;

  // typed expectation travels with the item it belongs to
  logic row_typed;
  fix_t row_fix;

  row_t       dir_tab [$];
  logic [7:0] burst [$];

  function automatic bit char_is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // advance the shadow parser by one byte, returns 1 when a fix comes out
  function automatic bit parse_byte(input logic [7:0] b, output fix_t fix);
    bit fired;
    fired = 1'b0;
    fix = '0;
    if (pst <= ST_HDR6) begin
      pst = (b == HDR_SEQ[pst[2:0]]) ? state_e'(pst + 4'd1) : ST_HDR0;
    end else begin
      case (pst)
        ST_TIME, ST_STATUS, ST_SKIP: begin
          if (b == CH_COMMA) pst = state_e'(pst + 4'd1);
        end
        ST_LAT: begin
          if (b == CH_COMMA) begin
            pst = ST_NS;
            dig_idx = 0;
          end else if (char_is_digit(b) && dig_idx < LAT_KEEP && dig_idx < MEM_DEPTH) begin
            lat_mem[dig_idx] = 4'(b - CH_ZERO);
            dig_idx++;
          end
        end
        ST_LON: begin
          if (b == CH_COMMA) begin
            pst = ST_EW;
            dig_idx = 0;
          end else if (char_is_digit(b) && dig_idx < LON_KEEP && dig_idx < MEM_DEPTH) begin
            lon_mem[dig_idx] = 4'(b - CH_ZERO);
            dig_idx++;
          end
        end
        ST_NS: begin
          ns_byte = b;
          pst = ST_SKIP;
        end
        ST_EW: begin
          ew_byte = b;
          pst = ST_HDR0;
          for (int k = 0; k < LAT_OUT; k++) fix.lat[k] = lat_mem[k];
          for (int k = 0; k < LON_OUT; k++) fix.lon[k] = lon_mem[k];
          fix.ns = ns_byte;
          fix.ew = ew_byte;
          fired = 1'b1;
        end
        default: pst = ST_HDR0;
      endcase
    end
    return fired;
  endfunction

  task automatic send_item(input row_t r);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= r.b;
    row_typed     <= r.typed;
    row_fix       <= r.fix;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic add_text(input string s);
    row_t r;
    for (int k = 0; k < s.len(); k++) begin
      r = '0;
      r.b = s[k];
      dir_tab.push_back(r);
    end
  endtask

  function automatic logic [7:0] rand_non_comma();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_COMMA);
    return b;
  endfunction

  function automatic logic [7:0] rand_field_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return CH_ZERO + 8'($urandom_range(9));
    if (r == 7) return 8'h2E;
    return rand_non_comma();
  endfunction

  function automatic void push_field(input int unsigned max_len);
    int unsigned n;
    n = $urandom_range(max_len);
    for (int unsigned k = 0; k < n; k++) burst.push_back(rand_field_byte());
    burst.push_back(CH_COMMA);
  endfunction

  function automatic void build_sentence();
    int unsigned n;
    for (int k = 0; k < HDR_LEN; k++) burst.push_back(HDR_SEQ[k]);
    push_field(10);
    n = $urandom_range(2);
    for (int unsigned k = 0; k < n; k++)
      burst.push_back($urandom_range(1) ? 8'h41 : rand_non_comma());
    burst.push_back(CH_COMMA);
    push_field(9);
    // hemisphere bytes are taken raw, so now and then anything goes
    if ($urandom_range(3) == 0) burst.push_back(8'($urandom_range(255)));
    else burst.push_back($urandom_range(1) ? CH_N : 8'h53);
    n = $urandom_range(3);
    for (int unsigned k = 0; k < n; k++) burst.push_back(rand_non_comma());
    burst.push_back(CH_COMMA);
    push_field(7);
    if ($urandom_range(3) == 0) burst.push_back(8'($urandom_range(255)));
    else burst.push_back($urandom_range(1) ? CH_E : 8'h57);
  endfunction

  function automatic void build_burst();
    int unsigned r;
    int unsigned k;
    int unsigned n;
    logic [7:0]  b;
    burst.delete();
    r = $urandom_range(99);
    if (r < 70) begin
      build_sentence();
    end else if (r < 80) begin
      // sentence cut short, the next one runs into it
      build_sentence();
      n = $urandom_range(burst.size() - 1);
      while (burst.size() > n) void'(burst.pop_back());
    end else if (r < 90) begin
      k = $urandom_range(HDR_LEN - 1);
      for (int unsigned j = 0; j < k; j++) burst.push_back(HDR_SEQ[j]);
      do b = 8'($urandom_range(255)); while (b == HDR_SEQ[k]);
      burst.push_back(b);
    end else begin
      n = $urandom_range(8, 1);
      for (int unsigned j = 0; j < n; j++) burst.push_back(8'($urandom_range(255)));
    end
  endfunction

  // input side: shadow parser sees every accepted item
  always @(posedge clk_i) begin
    fix_t pred;
    bit   fired;
    if (rst_ni && in_if.valid && in_if.ready) begin
      fired = parse_byte(in_if.rx_byte, pred);
      if (row_typed) pending_fixes.push_back(row_fix);
      else if (fired) pending_fixes.push_back(pred);
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle);
  end

  // output side
  always @(posedge clk_i) begin
    fix_t want;
    fix_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.lat = {out_if.lat_digit_4, out_if.lat_digit_3, out_if.lat_digit_2,
                 out_if.lat_digit_1, out_if.lat_digit_0};
      got.lon = {out_if.lon_digit_3, out_if.lon_digit_2, out_if.lon_digit_1,
                 out_if.lon_digit_0};
      got.ns = out_if.hemisphere_ns;
      got.ew = out_if.hemisphere_ew;
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result item, expected none got %h", $time, got);
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        for (int k = 0; k < LAT_OUT; k++)
          if (got.lat[k] !== want.lat[k]) begin
            $display("%0t: lat_digit_%0d expected %0d got %0d", $time, k,
                     want.lat[k], got.lat[k]);
            errors++;
          end
        for (int k = 0; k < LON_OUT; k++)
          if (got.lon[k] !== want.lon[k]) begin
            $display("%0t: lon_digit_%0d expected %0d got %0d", $time, k,
                     want.lon[k], got.lon[k]);
            errors++;
          end
        if (got.ns !== want.ns) begin
          $display("%0t: hemisphere_ns expected %h got %h", $time, want.ns, got.ns);
          errors++;
        end
        if (got.ew !== want.ew) begin
          $display("%0t: hemisphere_ew expected %h got %h", $time, want.ew, got.ew);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t r;
    int   target;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    row_typed     = 1'b0;
    row_fix       = '0;
    pst           = ST_HDR0;
    dig_idx       = 0;
    lat_mem       = '{4'd1, 4'd1, 4'd3, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0};
    lon_mem       = '{4'd2, 4'd4, 4'd1, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0};
    ns_byte       = CH_N;
    ew_byte       = CH_E;

    // broken header, then a sentence with a long latitude, empty longitude
    // and extreme hemisphere bytes
    add_text("$GNX$GNRMC,,,987654,");
    r = '0;
    r.b = 8'h00;
    dir_tab.push_back(r);
    add_text(",,");
    r.b = 8'hFF;
    r.typed = 1'b1;
    r.fix = '{lat: {4'd5, 4'd6, 4'd7, 4'd8, 4'd9}, lon: {4'd7, 4'd1, 4'd4, 4'd2},
              ns: 8'h00, ew: 8'hFF};
    dir_tab.push_back(r);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 22; snk_idle = 46; end
        1: begin src_idle = 46; snk_idle = 22; end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      target = dir_tab.size() + (phase + 1) * 650;
      while (sent < target) begin
        build_burst();
        foreach (burst[i]) begin
          r = '0;
          r.b = burst[i];
          send_item(r);
        end
      end
    end
    in_if.valid <= 1'b0;

    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_fixes.size() == 0) begin
      $display("PASS nmea_rmc_position_parser_core");
    end else begin
      $display("FAIL nmea_rmc_position_parser_core");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL nmea_rmc_position_parser_core");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/nrmc_pkg.sv
rtl/nrmc_in_if.sv
rtl/nrmc_out_if.sv
rtl/nmea_rmc_position_parser_core.sv
dv/tb_top.sv
